/* rtl/tuple_record_parser_unit_assert.svh */
// Assertion macros of the record parser, used by the result queue module.
// Each macro expands to one labeled concurrent assertion with a reset guard.
`ifndef TUPLE_RECORD_PARSER_UNIT_ASSERT_SVH
`define TUPLE_RECORD_PARSER_UNIT_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define TRP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define TRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/trp_pkg.sv */
// Shared types and constants of the record parser.
// Used by the parser front end, the result queue, the emitter and the top level.
package trp_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic CFG_INT_CODE = 1'b0;
  localparam logic CFG_STR_CODE = 1'b1;

  typedef enum logic [2:0] {
    KIND_INT       = 3'd0,
    KIND_STR_BYTE  = 3'd1,
    KIND_EMPTY_STR = 3'd2,
    KIND_EMPTY_REC = 3'd3,
    KIND_ERROR     = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNC     = 2'd1,
    ERR_STR_LONG  = 2'd2,
    ERR_BAD_TYPE  = 2'd3
  } err_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] value;
    logic [15:0]        field_index;
    logic               end_of_field;
    logic               end_of_record;
    err_e               error_code;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

/* rtl/trp_parser.sv */
// Front end of the record parser: accepts bytes, tracks the record state
// and pushes finished results into the result queue. Depends on trp_pkg.
module trp_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [7:0]            cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  buffer_end_i,
  input  trp_pkg::fifo_status_t fifo_status_i,
  output logic                  push_o,
  output trp_pkg::result_t      result_o
);

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_COUNT_HI = 3'd1,
    PH_TYPE     = 3'd2,
    PH_INT      = 3'd3,
    PH_LEN      = 3'd4,
    PH_STR      = 3'd5,
    PH_DRAIN    = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  byte_pos_q, byte_pos_d;
  logic [15:0] fields_left_q, fields_left_d;
  logic [15:0] cur_field_q, cur_field_d;
  logic [31:0] asm_q, asm_d;
  logic [31:0] str_left_q, str_left_d;
  logic [7:0]  int_code_q, str_code_q;

  logic                  accept;
  logic                  last;
  logic [31:0]           asm_new;
  logic [15:0]           count;
  logic                  fin;
  trp_pkg::kind_e        fin_kind;
  logic [31:0]           fin_value;
  logic                  emit;
  trp_pkg::result_t      res;

  assign in_stall_o = fifo_status_i.full;
  assign accept     = in_valid_i && !fifo_status_i.full;
  assign last       = buffer_end_i;
  assign asm_new    = asm_q | (32'(data_byte_i) << {byte_pos_q, 3'b000});
  assign count      = {data_byte_i, asm_q[7:0]};

  always_comb begin
    phase_d       = phase_q;
    byte_pos_d    = byte_pos_q;
    fields_left_d = fields_left_q;
    cur_field_d   = cur_field_q;
    asm_d         = asm_q;
    str_left_d    = str_left_q;
    fin           = 1'b0;
    fin_kind      = trp_pkg::KIND_INT;
    fin_value     = '0;
    emit          = 1'b0;
    res           = '0;
    res.kind       = trp_pkg::KIND_ERROR;
    res.error_code = trp_pkg::ERR_NONE;
    if (accept) begin
      case (phase_q)
        PH_COUNT_HI: begin
          cur_field_d = '0;
          if (count == 16'd0) begin
            fields_left_d     = '0;
            emit              = 1'b1;
            res.kind          = trp_pkg::KIND_EMPTY_REC;
            res.end_of_record = 1'b1;
            phase_d           = last ? PH_IDLE : PH_DRAIN;
            byte_pos_d        = '0;
          end else begin
            fields_left_d = count;
            if (last) begin
              emit           = 1'b1;
              res.error_code = trp_pkg::ERR_TRUNC;
              phase_d        = PH_IDLE;
              byte_pos_d     = '0;
            end else begin
              phase_d = PH_TYPE;
            end
          end
        end
        PH_TYPE: begin
          if (data_byte_i == int_code_q || data_byte_i == str_code_q) begin
            phase_d    = (data_byte_i == int_code_q) ? PH_INT : PH_LEN;
            byte_pos_d = '0;
            asm_d      = '0;
            if (last) begin
              emit            = 1'b1;
              res.field_index = cur_field_q;
              res.error_code  = trp_pkg::ERR_TRUNC;
              phase_d         = PH_IDLE;
            end
          end else begin
            emit            = 1'b1;
            res.field_index = cur_field_q;
            res.error_code  = trp_pkg::ERR_BAD_TYPE;
            phase_d         = last ? PH_IDLE : PH_DRAIN;
            byte_pos_d      = '0;
          end
        end
        PH_INT, PH_LEN: begin
          asm_d = asm_new;
          if (byte_pos_q != 2'd3) begin
            byte_pos_d = byte_pos_q + 2'd1;
            if (last) begin
              emit            = 1'b1;
              res.field_index = cur_field_q;
              res.error_code  = trp_pkg::ERR_TRUNC;
              phase_d         = PH_IDLE;
              byte_pos_d      = '0;
            end
          end else begin
            byte_pos_d = '0;
            if (phase_q == PH_INT) begin
              fin       = 1'b1;
              fin_kind  = trp_pkg::KIND_INT;
              fin_value = asm_new;
            end else if (asm_new == 32'd0) begin
              fin       = 1'b1;
              fin_kind  = trp_pkg::KIND_EMPTY_STR;
              fin_value = '0;
            end else if (last) begin
              emit            = 1'b1;
              res.field_index = cur_field_q;
              res.error_code  = trp_pkg::ERR_STR_LONG;
              phase_d         = PH_IDLE;
            end else begin
              str_left_d = asm_new;
              phase_d    = PH_STR;
            end
          end
        end
        PH_STR: begin
          if (str_left_q <= 32'd1) begin
            str_left_d = '0;
            fin        = 1'b1;
            fin_kind   = trp_pkg::KIND_STR_BYTE;
            fin_value  = 32'(data_byte_i);
          end else begin
            str_left_d      = str_left_q - 32'd1;
            emit            = 1'b1;
            res.kind        = trp_pkg::KIND_STR_BYTE;
            res.value       = 32'(data_byte_i);
            res.field_index = cur_field_q;
            if (last) begin
              res.error_code = trp_pkg::ERR_STR_LONG;
              phase_d        = PH_IDLE;
              byte_pos_d     = '0;
            end
          end
        end
        PH_DRAIN: begin
          if (last) begin
            phase_d    = PH_IDLE;
            byte_pos_d = '0;
          end
        end
        default: begin
          cur_field_d   = '0;
          fields_left_d = '0;
          byte_pos_d    = '0;
          asm_d         = 32'(data_byte_i);
          if (last) begin
            emit           = 1'b1;
            res.error_code = trp_pkg::ERR_TRUNC;
            phase_d        = PH_IDLE;
          end else begin
            phase_d = PH_COUNT_HI;
          end
        end
      endcase

      if (fin) begin
        emit             = 1'b1;
        res.kind         = fin_kind;
        res.value        = fin_value;
        res.field_index  = cur_field_q;
        res.end_of_field = 1'b1;
        byte_pos_d       = '0;
        if (fields_left_q <= 16'd1) begin
          fields_left_d     = '0;
          res.end_of_record = 1'b1;
          phase_d           = last ? PH_IDLE : PH_DRAIN;
        end else begin
          fields_left_d = fields_left_q - 16'd1;
          cur_field_d   = cur_field_q + 16'd1;
          if (last) begin
            res.error_code = trp_pkg::ERR_TRUNC;
            phase_d        = PH_IDLE;
          end else begin
            phase_d = PH_TYPE;
          end
        end
      end
    end
  end

  assign push_o   = emit;
  assign result_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      byte_pos_q    <= '0;
      fields_left_q <= '0;
      cur_field_q   <= '0;
      asm_q         <= '0;
      str_left_q    <= '0;
      int_code_q    <= 8'd0;
      str_code_q    <= 8'd1;
    end else begin
      phase_q       <= phase_d;
      byte_pos_q    <= byte_pos_d;
      fields_left_q <= fields_left_d;
      cur_field_q   <= cur_field_d;
      asm_q         <= asm_d;
      str_left_q    <= str_left_d;
      if (cfg_we_i && cfg_idx_i == trp_pkg::CFG_INT_CODE) begin
        int_code_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == trp_pkg::CFG_STR_CODE) begin
        str_code_q <= cfg_data_i;
      end
    end
  end

endmodule

/* rtl/trp_fifo.sv */
// Short result queue between the parser front end and the output emitter.
// Depends on trp_pkg and on the assertion macros header.
`include "tuple_record_parser_unit_assert.svh"

module trp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  trp_pkg::result_t      data_i,
  input  logic                  pop_i,
  output trp_pkg::fifo_status_t status_o,
  output trp_pkg::result_t      data_o
);

  trp_pkg::result_t               mem_q [trp_pkg::FIFO_DEPTH];
  logic [trp_pkg::FIFO_AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [trp_pkg::FIFO_AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [trp_pkg::FIFO_CW-1:0]    count_q, count_d;

  assign status_o.full  = (count_q == trp_pkg::FIFO_CW'(trp_pkg::FIFO_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign data_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + trp_pkg::FIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + trp_pkg::FIFO_AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + trp_pkg::FIFO_CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - trp_pkg::FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `TRP_ASSERT(a_count_range, clk_i, rst_ni, count_q <= trp_pkg::FIFO_CW'(trp_pkg::FIFO_DEPTH), "queue count out of range")
  `TRP_ASSERT(a_no_overflow, clk_i, rst_ni, !(push_i && status_o.full), "push into full queue")
  `TRP_ASSERT(a_no_underflow, clk_i, rst_ni, !(pop_i && status_o.empty), "pop from empty queue")
  `TRP_ASSERT_NEXT(a_push_grows, clk_i, rst_ni, push_i && !pop_i, count_q == $past(count_q) + trp_pkg::FIFO_CW'(1), "queue count did not grow")

endmodule

/* rtl/trp_emitter.sv */
// Back end of the record parser: takes results from the queue into the
// output register and holds them while the receiver stalls. Depends on trp_pkg.
module trp_emitter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  trp_pkg::fifo_status_t fifo_status_i,
  input  trp_pkg::result_t      fifo_data_i,
  output logic                  pop_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output trp_pkg::result_t      result_o
);

  logic             valid_q, valid_d;
  trp_pkg::result_t result_q;

  assign pop_o = !fifo_status_i.empty && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d = valid_q;
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      result_q <= fifo_data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

/* rtl/tuple_record_parser_unit.sv */
// Top level of the streaming record parser: type-length-value bytes in,
// integer values and string bytes out. Depends on trp_pkg and its submodules.
//
// The input channel takes one record byte per item, with buffer_end marking
// the last byte of the buffer. The output channel gives at most one result
// per input item: an integer, a string byte, an empty string, an empty record
// or an error, with field index and end-of-field and end-of-record flags.
// Both channels use valid and stall; an item moves when valid is high and
// stall is low. The two type codes are written through the configuration
// port; the user must write them only while no record is in flight, and
// the block itself does not enforce it. A byte is taken every cycle while
// the four-entry result queue has room, so the sustained rate is one byte
// per cycle. Each result passes the queue and then the output register.
// When the receiver stalls, the output register holds its result and the
// queue fills; input stall rises only once the queue is full.
// Reset empties the queue, clears out_valid, returns the parser to idle
// and restores the type codes to 0 for integers and 1 for strings.
module tuple_record_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               buffer_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         kind_o,
  output logic signed [31:0] value_o,
  output logic [15:0]        field_index_o,
  output logic               end_of_field_o,
  output logic               end_of_record_o,
  output logic [1:0]         error_code_o
);

  trp_pkg::fifo_status_t fifo_status;
  trp_pkg::result_t      push_data;
  trp_pkg::result_t      pop_data;
  trp_pkg::result_t      out_result;
  logic                  push;
  logic                  pop;

  trp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .data_byte_i   (data_byte_i),
    .buffer_end_i  (buffer_end_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .result_o      (push_data)
  );

  trp_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (push_data),
    .pop_i    (pop),
    .status_o (fifo_status),
    .data_o   (pop_data)
  );

  trp_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fifo_status_i (fifo_status),
    .fifo_data_i   (pop_data),
    .pop_o         (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .result_o      (out_result)
  );

  assign kind_o          = out_result.kind;
  assign value_o         = out_result.value;
  assign field_index_o   = out_result.field_index;
  assign end_of_field_o  = out_result.end_of_field;
  assign end_of_record_o = out_result.end_of_record;
  assign error_code_o    = out_result.error_code;

endmodule

/* tb/tb_tuple_record_parser_unit.sv */
// Self-checking testbench for tuple_record_parser_unit: directed and random record
// buffers, with results predicted in the bench and compared field by field.
// Depends on trp_pkg and the parser RTL.
module tb_tuple_record_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 200000;
  localparam int DrainCycles  = 12;
  localparam int PhaseItems   = 125;
  localparam int NumDirected  = 30;

  typedef enum logic [2:0] {
    ST_IDLE, ST_COUNT_HI, ST_TYPE, ST_INT, ST_LEN, ST_STR, ST_DRAIN
  } parse_st_e;

  typedef struct packed {
    logic [7:0]       data;
    logic             last;
    logic             typed;
    logic             has;
    trp_pkg::result_t res;
  } stim_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_idx_i = 1'b0;
  logic [7:0]         cfg_data_i = 8'd0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         data_byte_i = 8'd0;
  logic               buffer_end_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         kind_o;
  logic signed [31:0] value_o;
  logic [15:0]        field_index_o;
  logic               end_of_field_o;
  logic               end_of_record_o;
  logic [1:0]         error_code_o;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int parsed_items = 0;
  int cycle_count = 0;

  trp_pkg::result_t pending_results [$];

  parse_st_e   st = ST_IDLE;
  logic [1:0]  byte_pos = '0;
  logic [15:0] fields_left = '0;
  logic [15:0] cur_field = '0;
  logic [31:0] word = '0;
  logic [31:0] str_left = '0;
  logic [7:0]  int_code = 8'd0;
  logic [7:0]  str_code = 8'd1;

  stim_row_t directed_rows [NumDirected] = '{
    '{8'h02, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b1, 1'b1,
      '{trp_pkg::KIND_INT, 32'sh80000000, 16'd0, 1'b1, 1'b0, trp_pkg::ERR_NONE}},
    '{8'h01, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, 1'b1,
      '{trp_pkg::KIND_EMPTY_STR, 32'sd0, 16'd1, 1'b1, 1'b1, trp_pkg::ERR_NONE}},
    '{8'hAB, 1'b0, 1'b1, 1'b0, '0},
    '{8'hCD, 1'b1, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b1, 1'b1, 1'b1,
      '{trp_pkg::KIND_EMPTY_REC, 32'sd0, 16'd0, 1'b0, 1'b1, trp_pkg::ERR_NONE}},
    '{8'h01, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h07, 1'b1, 1'b1, 1'b1,
      '{trp_pkg::KIND_ERROR, 32'sd0, 16'd0, 1'b0, 1'b0, trp_pkg::ERR_BAD_TYPE}},
    '{8'hFF, 1'b1, 1'b1, 1'b1,
      '{trp_pkg::KIND_ERROR, 32'sd0, 16'd0, 1'b0, 1'b0, trp_pkg::ERR_TRUNC}},
    '{8'h02, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h01, 1'b0, 1'b0, 1'b0, '0},
    '{8'h03, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, 1'b0, '0},
    '{8'h42, 1'b0, 1'b0, 1'b0, '0},
    '{8'h43, 1'b1, 1'b0, 1'b0, '0}
  };

  tuple_record_parser_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .buffer_end_i    (buffer_end_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .value_o         (value_o),
    .field_index_o   (field_index_o),
    .end_of_field_o  (end_of_field_o),
    .end_of_record_o (end_of_record_o),
    .error_code_o    (error_code_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic trp_pkg::result_t make_result(trp_pkg::kind_e k, logic [31:0] v,
                                                   logic [15:0] idx, logic eof, logic eor,
                                                   trp_pkg::err_e e);
    trp_pkg::result_t r;
    r.kind = k;
    r.value = v;
    r.field_index = idx;
    r.end_of_field = eof;
    r.end_of_record = eor;
    r.error_code = e;
    return r;
  endfunction

  function automatic trp_pkg::result_t error_result(trp_pkg::err_e e);
    return make_result(trp_pkg::KIND_ERROR, '0, cur_field, 1'b0, 1'b0, e);
  endfunction

  function automatic void stop_record(logic last);
    st = last ? ST_IDLE : ST_DRAIN;
    byte_pos = '0;
  endfunction

  function automatic trp_pkg::result_t close_field(trp_pkg::kind_e k, logic [31:0] v,
                                                   logic last);
    trp_pkg::result_t r;
    if (fields_left <= 16'd1) begin
      fields_left = '0;
      r = make_result(k, v, cur_field, 1'b1, 1'b1, trp_pkg::ERR_NONE);
      stop_record(last);
      return r;
    end
    r = make_result(k, v, cur_field, 1'b1, 1'b0,
                    last ? trp_pkg::ERR_TRUNC : trp_pkg::ERR_NONE);
    fields_left = fields_left - 16'd1;
    cur_field = cur_field + 16'd1;
    byte_pos = '0;
    st = last ? ST_IDLE : ST_TYPE;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                    output trp_pkg::result_t r);
    logic [15:0] count;
    r = '0;
    case (st)
      ST_COUNT_HI: begin
        count = {b, word[7:0]};
        cur_field = '0;
        fields_left = count;
        if (count == 16'd0) begin
          r = make_result(trp_pkg::KIND_EMPTY_REC, '0, '0, 1'b0, 1'b1, trp_pkg::ERR_NONE);
          stop_record(last);
          return 1'b1;
        end
        if (last) begin
          r = error_result(trp_pkg::ERR_TRUNC);
          stop_record(1'b1);
          return 1'b1;
        end
        st = ST_TYPE;
        return 1'b0;
      end
      ST_TYPE: begin
        if (b == int_code) begin
          st = ST_INT;
        end else if (b == str_code) begin
          st = ST_LEN;
        end else begin
          r = error_result(trp_pkg::ERR_BAD_TYPE);
          stop_record(last);
          return 1'b1;
        end
        byte_pos = '0;
        word = '0;
        if (last) begin
          r = error_result(trp_pkg::ERR_TRUNC);
          stop_record(1'b1);
          return 1'b1;
        end
        return 1'b0;
      end
      ST_INT, ST_LEN: begin
        word = word | ({24'd0, b} << (8 * byte_pos));
        if (byte_pos != 2'd3) begin
          byte_pos = byte_pos + 2'd1;
          if (last) begin
            r = error_result(trp_pkg::ERR_TRUNC);
            stop_record(1'b1);
            return 1'b1;
          end
          return 1'b0;
        end
        byte_pos = '0;
        if (st == ST_INT) begin
          r = close_field(trp_pkg::KIND_INT, word, last);
          return 1'b1;
        end
        if (word == 32'd0) begin
          r = close_field(trp_pkg::KIND_EMPTY_STR, '0, last);
          return 1'b1;
        end
        if (last) begin
          r = error_result(trp_pkg::ERR_STR_LONG);
          stop_record(1'b1);
          return 1'b1;
        end
        str_left = word;
        st = ST_STR;
        return 1'b0;
      end
      ST_STR: begin
        if (str_left <= 32'd1) begin
          str_left = '0;
          r = close_field(trp_pkg::KIND_STR_BYTE, {24'd0, b}, last);
          return 1'b1;
        end
        str_left = str_left - 32'd1;
        r = make_result(trp_pkg::KIND_STR_BYTE, {24'd0, b}, cur_field, 1'b0, 1'b0,
                        last ? trp_pkg::ERR_STR_LONG : trp_pkg::ERR_NONE);
        if (last) stop_record(1'b1);
        return 1'b1;
      end
      ST_DRAIN: begin
        if (last) stop_record(1'b1);
        return 1'b0;
      end
      default: begin
        cur_field = '0;
        fields_left = '0;
        byte_pos = '0;
        word = {24'd0, b};
        if (last) begin
          r = error_result(trp_pkg::ERR_TRUNC);
          stop_record(1'b1);
          return 1'b1;
        end
        st = ST_COUNT_HI;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last,
                           output bit has, output trp_pkg::result_t r);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    buffer_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    parsed_items++;
    has = parse_byte(b, last, r);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == trp_pkg::CFG_INT_CODE) int_code = val;
    else str_code = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_buffer();
    logic [7:0]       stream [$];
    logic [31:0]      v;
    logic [15:0]      count;
    int               cut;
    bit               ended;
    bit               has;
    trp_pkg::result_t r;
    ended = 1'b0;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 6)) stream = {stream, 8'($urandom_range(255))};
    end else begin
      count = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
      if ($urandom_range(15) == 0) count = 16'($urandom);
      stream = {stream, count[7:0]};
      stream = {stream, count[15:8]};
      for (int f = 0; f < count && f < 5 && !ended; f++) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            stream = {stream, int_code};
            case ($urandom_range(4))
              0: v = 32'h7FFF_FFFF;
              1: v = 32'h8000_0000;
              2: v = 32'h0000_0000;
              3: v = 32'hFFFF_FFFF;
              default: v = $urandom;
            endcase
            for (int k = 0; k < 4; k++) stream = {stream, v[8*k +: 8]};
          end
          9: stream = {stream, 8'($urandom_range(255))};
          default: begin
            stream = {stream, str_code};
            case ($urandom_range(9))
              0, 1: v = 32'd0;
              2: v = $urandom;
              default: v = 32'($urandom_range(1, 5));
            endcase
            for (int k = 0; k < 4; k++) stream = {stream, v[8*k +: 8]};
            if (v > 32'd5) begin
              repeat ($urandom_range(0, 3)) stream = {stream, 8'($urandom_range(255))};
              ended = 1'b1;
            end else begin
              repeat (v) stream = {stream, 8'($urandom_range(255))};
            end
          end
        endcase
      end
      if (!ended) repeat ($urandom_range(0, 2)) stream = {stream, 8'($urandom_range(255))};
      if ($urandom_range(3) == 0) begin
        cut = $urandom_range(1, stream.size());
        stream = stream[0:cut-1];
      end
    end
    foreach (stream[k]) begin
      send_byte(stream[k], k == stream.size() - 1, has, r);
      if (has) pending_results = {pending_results, r};
    end
  endtask

  function automatic void check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected 'h%0h, actual 'h%0h", name, expv, actv);
      mismatch_count++;
    end
  endfunction

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    trp_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: kind %0d, value 'h%0h", kind_o, value_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("value", want.value, value_o);
        check_field("field_index", 32'(want.field_index), 32'(field_index_o));
        check_field("end_of_field", 32'(want.end_of_field), 32'(end_of_field_o));
        check_field("end_of_record", 32'(want.end_of_record), 32'(end_of_record_o));
        check_field("error_code", 32'(want.error_code), 32'(error_code_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tuple_record_parser_unit regression: fail");
      $finish;
    end
  end

  initial begin
    bit               has;
    trp_pkg::result_t r;
    int               phase_start;
    int               idle_pcts [4];
    int               stall_pcts [4];
    idle_pcts = '{0, 61, 0, 34};
    stall_pcts = '{0, 0, 61, 34};
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NumDirected; i++) begin
      send_byte(directed_rows[i].data, directed_rows[i].last, has, r);
      if (directed_rows[i].typed) begin
        if (directed_rows[i].has) begin
          pending_results = {pending_results, directed_rows[i].res};
        end
      end else if (has) begin
        pending_results = {pending_results, r};
      end
    end
    wait_for_results();

    for (int p = 0; p < 4; p++) begin
      case (p)
        1: begin
          write_reg(trp_pkg::CFG_INT_CODE, 8'hFF);
          write_reg(trp_pkg::CFG_STR_CODE, 8'h00);
        end
        2: begin
          write_reg(trp_pkg::CFG_INT_CODE, 8'h5A);
          write_reg(trp_pkg::CFG_STR_CODE, 8'h5A);
        end
        3: begin
          write_reg(trp_pkg::CFG_INT_CODE, 8'($urandom_range(255)));
          write_reg(trp_pkg::CFG_STR_CODE, 8'($urandom_range(255)));
        end
        default: ;
      endcase
      send_idle_pct = idle_pcts[p];
      recv_stall_pct = stall_pcts[p];
      phase_start = parsed_items;
      while (parsed_items - phase_start < PhaseItems) send_buffer();
      wait_for_results();
    end

    if (mismatch_count == 0) begin
      $display("tuple_record_parser_unit regression: pass");
    end else begin
      $display("tuple_record_parser_unit regression: fail");
    end
    $finish;
  end

endmodule
